// File: src/dual_image_container_splitter_assert.svh
// Assertion macros shared by the splitter RTL.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef DUAL_IMAGE_CONTAINER_SPLITTER_ASSERT_SVH
`define DUAL_IMAGE_CONTAINER_SPLITTER_ASSERT_SVH

// Same-cycle implication
`define DICS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DICS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/dics_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dics_pkg
// Types and codes of the dual image container splitter.
// ----------------------------------------------------------------------------
package dics_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
  localparam int HDR_CNT_W    = 5;

  localparam logic [63:0] MAGIC_RESET = 64'h0000_3144_5055_324B;

  // APB map: one 64-bit register at byte address 0
  localparam int          CFG_ADDR_W    = 4;
  localparam logic        CFG_IDX_MAGIC = 1'b0;

  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] ROUTE_NONE = 2'd0;
  localparam logic [1:0] ROUTE_FW   = 2'd1;
  localparam logic [1:0] ROUTE_FS   = 2'd2;

  localparam logic [1:0] STAGE_HEADER = 2'd0;
  localparam logic [1:0] STAGE_FW     = 2'd1;
  localparam logic [1:0] STAGE_FS     = 2'd2;
  localparam logic [1:0] STAGE_DONE   = 2'd3;

  localparam logic [3:0] STATUS_NONE       = 4'd0;
  localparam logic [3:0] STATUS_FW_BEGIN   = 4'd1;
  localparam logic [3:0] STATUS_FS_BEGIN   = 4'd2;
  localparam logic [3:0] STATUS_COMPLETE   = 4'd3;
  localparam logic [3:0] STATUS_BAD_MAGIC  = 4'd4;
  localparam logic [3:0] STATUS_ZERO_SIZE  = 4'd5;
  localparam logic [3:0] STATUS_INCOMPLETE = 4'd6;
  localparam logic [3:0] STATUS_END_OK     = 4'd7;
  localparam logic [3:0] STATUS_IGNORED    = 4'd8;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  route;
    logic [7:0]  out_byte;
    logic [3:0]  status;
    logic [31:0] image_size;
    logic [31:0] bytes_written;
  } result_t;

endpackage

// File: src/dics_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dics_cfg
// APB register file: holds the expected magic word.
// ----------------------------------------------------------------------------
module dics_cfg
  import dics_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  output logic [63:0]           magic_word
);

  logic sel_magic;

  // registers sit on 8-byte boundaries; bit 3 is the register index
  assign sel_magic = (paddr[3] == CFG_IDX_MAGIC);
  assign pready    = 1'b1;
  assign prdata    = sel_magic ? magic_word : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= MAGIC_RESET;
    end else if (psel && penable && pwrite && pready && sel_magic) begin
      magic_word <= pwdata;
    end
  end

endmodule

// File: src/dics_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dics_parser
// Container parser state and the single-pass step logic for one word.
// ----------------------------------------------------------------------------
module dics_parser
  import dics_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  item_t       item,
  input  logic [63:0] magic_word,
  output result_t     res
);

  logic                 active, active_next;
  logic [1:0]           stage, stage_next;
  logic [HDR_CNT_W-1:0] header_count, header_count_next;
  logic [31:0]          fw_size, fw_size_next;
  logic [31:0]          fs_size, fs_size_next;
  logic [31:0]          fw_done, fw_done_next;
  logic [31:0]          fs_done, fs_done_next;
  logic [31:0]          total_written, total_next;
  logic [7:0]           header_bytes [HEADER_BYTES];

  logic        hdr_we;
  logic        hdr_last;
  logic        clear_req;
  logic        magic_ok;
  logic [31:0] fw_hdr, fs_hdr;
  logic [31:0] fw_inc, fs_inc, tot_inc;

  assign hdr_last = (header_count == HDR_CNT_W'(HEADER_BYTES - 1));
  assign magic_ok = ({header_bytes[7], header_bytes[6], header_bytes[5], header_bytes[4],
                      header_bytes[3], header_bytes[2], header_bytes[1], header_bytes[0]}
                     == magic_word);
  assign fw_hdr   = {header_bytes[11], header_bytes[10], header_bytes[9], header_bytes[8]};
  // last size byte is the word on hand, not yet stored
  assign fs_hdr   = {item.data_byte, header_bytes[14], header_bytes[13], header_bytes[12]};
  assign fw_inc   = fw_done + 32'd1;
  assign fs_inc   = fs_done + 32'd1;
  assign tot_inc  = total_written + 32'd1;

  always_comb begin
    active_next       = active;
    stage_next        = stage;
    header_count_next = header_count;
    fw_size_next      = fw_size;
    fs_size_next      = fs_size;
    fw_done_next      = fw_done;
    fs_done_next      = fs_done;
    total_next        = total_written;
    hdr_we            = 1'b0;
    clear_req         = 1'b0;
    res               = '0;
    res.route         = ROUTE_NONE;
    res.status        = STATUS_IGNORED;

    case (item.kind)
      KIND_BEGIN: begin
        clear_req   = 1'b1;
        total_next  = 32'd0;
        active_next = 1'b1;
        res.status  = STATUS_NONE;
      end
      KIND_DATA: begin
        if (active && stage == STAGE_HEADER) begin
          hdr_we            = 1'b1;
          header_count_next = header_count + HDR_CNT_W'(1);
          res.status        = STATUS_NONE;
          if (hdr_last) begin
            if (!magic_ok) begin
              res.status  = STATUS_BAD_MAGIC;
              clear_req   = 1'b1;
              active_next = 1'b0;
            end else if (fw_hdr == 32'd0 || fs_hdr == 32'd0) begin
              res.status  = STATUS_ZERO_SIZE;
              clear_req   = 1'b1;
              active_next = 1'b0;
            end else begin
              fw_size_next   = fw_hdr;
              fs_size_next   = fs_hdr;
              stage_next     = STAGE_FW;
              res.status     = STATUS_FW_BEGIN;
              res.image_size = fw_hdr;
            end
          end
        end else if (active && stage == STAGE_FW) begin
          res.route    = ROUTE_FW;
          res.out_byte = item.data_byte;
          fw_done_next = fw_inc;
          total_next   = tot_inc;
          res.status   = STATUS_NONE;
          if (fw_inc == fw_size) begin
            stage_next     = STAGE_FS;
            res.status     = STATUS_FS_BEGIN;
            res.image_size = fs_size;
          end
        end else if (active && stage == STAGE_FS) begin
          res.route    = ROUTE_FS;
          res.out_byte = item.data_byte;
          fs_done_next = fs_inc;
          total_next   = tot_inc;
          res.status   = STATUS_NONE;
          if (fs_inc == fs_size) begin
            stage_next = STAGE_DONE;
            res.status = STATUS_COMPLETE;
          end
        end
      end
      KIND_END: begin
        if (stage == STAGE_DONE) begin
          res.status = STATUS_END_OK;
        end else begin
          res.status = STATUS_INCOMPLETE;
          clear_req  = 1'b1;
        end
        active_next = 1'b0;
      end
      default: begin
        res.status = STATUS_IGNORED;
      end
    endcase

    if (clear_req) begin
      stage_next        = STAGE_HEADER;
      header_count_next = '0;
      fw_size_next      = 32'd0;
      fs_size_next      = 32'd0;
      fw_done_next      = 32'd0;
      fs_done_next      = 32'd0;
    end

    res.bytes_written = total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      stage         <= STAGE_HEADER;
      header_count  <= '0;
      fw_size       <= 32'd0;
      fs_size       <= 32'd0;
      fw_done       <= 32'd0;
      fs_done       <= 32'd0;
      total_written <= 32'd0;
    end else if (fire) begin
      active        <= active_next;
      stage         <= stage_next;
      header_count  <= header_count_next;
      fw_size       <= fw_size_next;
      fs_size       <= fs_size_next;
      fw_done       <= fw_done_next;
      fs_done       <= fs_done_next;
      total_written <= total_next;
    end
  end

  // header store, no reset: read only once all sixteen bytes are in
  always_ff @(posedge clk) begin
    if (fire && hdr_we) begin
      header_bytes[header_count[HDR_IDX_W-1:0]] <= item.data_byte;
    end
  end

`include "dual_image_container_splitter_assert.svh"

  `DICS_ASSERT_NOW(a_count_full_past_header, clk, rst, stage != STAGE_HEADER,
    header_count == HDR_CNT_W'(HEADER_BYTES), "header count not full outside header stage")
  `DICS_ASSERT_NOW(a_fw_below_size, clk, rst, stage == STAGE_FW,
    fw_done < fw_size, "firmware count reached size without leaving stage")
  `DICS_ASSERT_NOW(a_route_status, clk, rst, fire && res.route != ROUTE_NONE,
    res.status == STATUS_NONE || res.status == STATUS_FS_BEGIN ||
    res.status == STATUS_COMPLETE, "forwarded byte with unexpected status")

endmodule

// File: src/dual_image_container_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_image_container_splitter
// Splits a two-image update container byte stream into firmware and
// filesystem bytes, with header checking and stage/error events.
// ----------------------------------------------------------------------------
// Use:
//  - item channel (item_valid/item_stall/item) carries one word per command:
//    begin container, data byte or end of stream.
//  - result channel (result_valid/result_stall/result) returns exactly one
//    word per item: route, forwarded byte, status, image size, byte count.
//  - APB port holds the expected 64-bit magic word at address 0; write it
//    only while no item is in flight.
// Pipeline: each item passes the input register, then the result register.
// Throughput: one item per cycle while the result is not stalled; the parser
// state loop closes between the two registers.
// Stall: both registers hold their words; item_stall rises only while the
// input register and the result register are both full and the result is
// stalled.
// Reset (rst, synchronous): empties both registers, clears the parser and
// byte count, and restores the default magic word. The header store is
// not cleared; it is always refilled before it is read.
// ----------------------------------------------------------------------------
module dual_image_container_splitter
  import dics_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // item channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  logic        s_valid;     // input register holds a word
  item_t       s_item;
  logic        advance;     // input word is processed this cycle
  logic        accept;
  result_t     step_res;
  logic [63:0] magic_word;

  // Input word moves on whenever the result register is empty or draining.
  assign advance    = s_valid && (!result_valid || !result_stall);
  assign item_stall = s_valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_item <= item;
    end
  end

  dics_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .magic_word (magic_word)
  );

  // Parser: state commits on the same edge that loads the result register.
  dics_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .item       (s_item),
    .magic_word (magic_word),
    .res        (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_res;
    end
  end

`include "dual_image_container_splitter_assert.svh"

  `DICS_ASSERT_NEXT(a_advance_fills_result, clk, rst, advance,
    result_valid, "processed word did not reach result register")
  `DICS_ASSERT_NOW(a_stall_only_when_full, clk, rst, item_stall,
    s_valid && result_valid && result_stall, "item stalled with room in pipeline")
  `DICS_ASSERT_NEXT(a_accept_fills_input, clk, rst, accept,
    s_valid, "accepted word not held in input register")

endmodule

// File: tb/tb_dual_image_container_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_image_container_splitter
// Self-checking bench for the dual image container splitter: a directed
// table, then random containers under four magic word settings. Every accepted
// result word is checked against a behavioural splitter model, or a typed row's fixed word.
// ----------------------------------------------------------------------------
module tb_dual_image_container_splitter;
  import dics_pkg::*;

  // kind code the block has no use for; it must be ignored
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // magic word is register 0; 64-bit register, so 8-byte slots
  localparam logic [CFG_ADDR_W-1:0] MAGIC_ADDR = '0;
  localparam int WORDS_PER_PHASE = 160;

  typedef enum int {
    SHAPE_WELL_FORMED,
    SHAPE_BAD_MAGIC,
    SHAPE_ZERO_SIZE,
    SHAPE_TRUNCATED
  } shape_t;

  // one row of the directed table; want is used only where typed is set
  typedef struct packed {
    item_t   word;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [63:0]           pwdata = '0;
  logic [63:0]           prdata;
  logic                  pready;

  dual_image_container_splitter dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Splitter model state: a private copy of the parser, the byte count and
  // the magic word as the block should hold them after each accepted word.
  // --------------------------------------------------------------------------
  bit          run_active;
  logic [1:0]  parse_stage;
  logic [4:0]  hdr_count;
  logic [7:0]  hdr_store [HEADER_BYTES];
  logic [31:0] fw_size, fs_size, fw_count, fs_count;
  logic [31:0] byte_total;
  logic [63:0] magic_cfg;

  result_t     split_q[$];     // expected result words, oldest first
  result_t     seen_want;
  int          fail_count = 0;
  int          useful_words = 0;  // accepted words the block does not ignore
  int          src_max_gap = 10;
  int          sink_max_gap = 10;
  int          stall_left = 0;

  // error, an incomplete end of stream and begin all drop the parser back to the header
  function automatic void reset_parse();
    parse_stage = STAGE_HEADER;
    hdr_count   = '0;
    fw_size     = '0;
    fs_size     = '0;
    fw_count    = '0;
    fs_count    = '0;
  endfunction

  function automatic result_t split_predict(item_t w);
    result_t     r;
    bit          magic_ok;
    logic [31:0] fw, fs;
    r = '0;
    r.status = STATUS_IGNORED;
    case (w.kind)
      KIND_BEGIN: begin
        reset_parse();
        byte_total = '0;
        run_active = 1'b1;
        r.status   = STATUS_NONE;
      end
      KIND_DATA: begin
        if (run_active && parse_stage == STAGE_HEADER) begin
          hdr_store[hdr_count[3:0]] = w.data_byte;
          hdr_count = hdr_count + 5'd1;
          r.status  = STATUS_NONE;
          if (hdr_count >= HEADER_BYTES) begin
            magic_ok = 1'b1;
            for (int i = 0; i < 8; i++)
              if (hdr_store[i] != magic_cfg[8*i +: 8]) magic_ok = 1'b0;
            // sizes are little-endian: lowest byte first
            fw = {hdr_store[11], hdr_store[10], hdr_store[9], hdr_store[8]};
            fs = {hdr_store[15], hdr_store[14], hdr_store[13], hdr_store[12]};
            if (!magic_ok) begin
              r.status = STATUS_BAD_MAGIC;
              reset_parse();
              run_active = 1'b0;
            end else if (fw == 0 || fs == 0) begin
              r.status = STATUS_ZERO_SIZE;
              reset_parse();
              run_active = 1'b0;
            end else begin
              fw_size      = fw;
              fs_size      = fs;
              parse_stage  = STAGE_FW;
              r.status     = STATUS_FW_BEGIN;
              r.image_size = fw;
            end
          end
        end else if (run_active && parse_stage == STAGE_FW) begin
          r.route    = ROUTE_FW;
          r.out_byte = w.data_byte;
          fw_count   = fw_count + 1;
          byte_total = byte_total + 1;
          r.status   = STATUS_NONE;
          if (fw_count == fw_size) begin
            parse_stage  = STAGE_FS;
            r.status     = STATUS_FS_BEGIN;
            r.image_size = fs_size;
          end
        end else if (run_active && parse_stage == STAGE_FS) begin
          r.route    = ROUTE_FS;
          r.out_byte = w.data_byte;
          fs_count   = fs_count + 1;
          byte_total = byte_total + 1;
          r.status   = STATUS_NONE;
          if (fs_count == fs_size) begin
            parse_stage = STAGE_DONE;
            r.status    = STATUS_COMPLETE;
          end
        end
        // inactive, or done: ignored and nothing moves
      end
      KIND_END: begin
        // applies even with no container open; a finished one stays done
        if (parse_stage == STAGE_DONE) begin
          r.status = STATUS_END_OK;
        end else begin
          r.status = STATUS_INCOMPLETE;
          reset_parse();
        end
        run_active = 1'b0;
      end
      default: ;
    endcase
    r.bytes_written = byte_total;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Item side. Everything is driven with NBAs just after a rising edge; a
  // word counts as accepted at the first edge that sees valid without stall.
  // With no gap the next word follows straight on, so valid stays high.
  // --------------------------------------------------------------------------
  task automatic send_word(input item_t w, input bit typed, input result_t want);
    int      gap;
    result_t pred;
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (item_stall);
    // model always advances; typed rows replace its answer with a fixed one
    pred = split_predict(w);
    if (pred.status != STATUS_IGNORED) useful_words++;
    split_q.push_back(typed ? want : pred);
  endtask

  task automatic send(input logic [1:0] kind, input logic [7:0] data_byte);
    item_t w;
    w.kind      = kind;
    w.data_byte = data_byte;
    send_word(w, 1'b0, '0);
  endtask

  // every word yields a result, so an empty queue means the block is idle
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (split_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one APB transfer: setup cycle, then access until pready
  task automatic cfg_xfer(input bit wr, input logic [63:0] wdata,
                          output logic [63:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MAGIC_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_magic(input logic [63:0] value);
    logic [63:0] rb;
    cfg_xfer(1'b1, value, rb);
    magic_cfg = value;
    cfg_xfer(1'b0, '0, rb);
    if (rb !== value) begin
      $display("%0t: magic readback expected %h got %h", $time, value, rb);
      fail_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Random containers. Well-formed ones dominate so the firmware and
  // filesystem stages get real traffic; the rest break the header or cut
  // the stream short. Trailing bytes after an error or completion land in
  // the ignore path.
  // --------------------------------------------------------------------------
  task automatic send_container(input shape_t shape);
    logic [7:0]  hdr [HEADER_BYTES];
    logic [63:0] magic;
    logic [31:0] fw_len, fs_len;
    longint      body;
    int          extra;
    fw_len = $urandom_range(1, 12);
    fs_len = $urandom_range(1, 12);
    if ($urandom_range(0, 15) == 0) fw_len = $urandom_range(13, 80);
    if ($urandom_range(0, 15) == 0) fs_len = $urandom_range(13, 80);
    magic = magic_cfg;
    case (shape)
      SHAPE_BAD_MAGIC: magic = magic ^ (64'd1 << $urandom_range(0, 63));
      SHAPE_ZERO_SIZE: begin
        case ($urandom_range(0, 2))
          0: fw_len = '0;
          1: fs_len = '0;
          default: begin
            fw_len = '0;
            fs_len = '0;
          end
        endcase
      end
      SHAPE_TRUNCATED: begin
        // huge sizes exercise the high size bits; the stream never gets there
        if ($urandom_range(0, 1) == 1) begin
          fw_len = $urandom | 32'd1;
          fs_len = $urandom | 32'd1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 8; i++) hdr[i] = magic[8*i +: 8];
    for (int i = 0; i < 4; i++) begin
      hdr[8 + i]  = fw_len[8*i +: 8];
      hdr[12 + i] = fs_len[8*i +: 8];
    end

    body = HEADER_BYTES;
    if (shape == SHAPE_WELL_FORMED) body += longint'(fw_len) + longint'(fs_len);
    if (shape == SHAPE_TRUNCATED) begin
      body += (longint'(fw_len) + longint'(fs_len) > 60) ? 60
              : longint'(fw_len) + longint'(fs_len);
      body = $urandom_range(0, int'(body) - 1);
    end

    src_max_gap  = ($urandom_range(0, 3) == 0) ? 0 : 10;
    sink_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;

    send(KIND_BEGIN, 8'($urandom_range(0, 255)));
    for (longint i = 0; i < body; i++)
      send(KIND_DATA, (i < HEADER_BYTES) ? hdr[i] : 8'($urandom_range(0, 255)));
    if (shape != SHAPE_TRUNCATED) begin
      extra = $urandom_range(0, 2);
      repeat (extra) send(KIND_DATA, 8'($urandom_range(0, 255)));
    end
    // sometimes no end at all: the next begin cuts in
    if ($urandom_range(0, 4) != 0) send(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send(KIND_UNUSED, 8'($urandom_range(0, 255)));
      1: send(KIND_DATA, 8'($urandom_range(0, 255)));
      default: send(KIND_END, 8'($urandom_range(0, 255)));
    endcase
  endtask

  function automatic stim_row_t row(
    input logic [1:0] k, input logic [7:0] b, input bit typed = 1'b0,
    input logic [1:0] rt = ROUTE_NONE, input logic [7:0] ob = '0,
    input logic [3:0] st = STATUS_NONE, input logic [31:0] sz = '0,
    input logic [31:0] bw = '0);
    stim_row_t s;
    s.word.kind      = k;
    s.word.data_byte = b;
    s.typed          = typed;
    s.want.route         = rt;
    s.want.out_byte      = ob;
    s.want.status        = st;
    s.want.image_size    = sz;
    s.want.bytes_written = bw;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall per word, checks in the same edge process.
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] got,
                                      input logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (split_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, result);
          fail_count++;
        end else begin
          seen_want = split_q.pop_front();
          check_field("route", result.route, seen_want.route);
          check_field("out_byte", result.out_byte, seen_want.out_byte);
          check_field("status", result.status, seen_want.status);
          check_field("image_size", result.image_size, seen_want.image_size);
          check_field("bytes_written", result.bytes_written,
                      seen_want.bytes_written);
        end
        stall_left = $urandom_range(0, sink_max_gap);
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  stim_row_t   dir_rows[$];
  logic [63:0] magic_plan [4];

  initial begin
    int     phase_start;
    int     pick;
    // model mirrors the reset state; header store starts clear
    run_active = 1'b0;
    reset_parse();
    byte_total = '0;
    magic_cfg  = MAGIC_RESET;
    foreach (hdr_store[i]) hdr_store[i] = '0;

    // Directed: stray words with nothing open, then one minimal container
    // (one byte each image) with both byte extremes, then late words.
    dir_rows.push_back(row(KIND_DATA, 8'hA5, 1'b1, ROUTE_NONE, 8'h00, STATUS_IGNORED));
    dir_rows.push_back(row(KIND_UNUSED, 8'hFF, 1'b1, ROUTE_NONE, 8'h00, STATUS_IGNORED));
    dir_rows.push_back(row(KIND_END, 8'h00, 1'b1, ROUTE_NONE, 8'h00, STATUS_INCOMPLETE));
    dir_rows.push_back(row(KIND_BEGIN, 8'h00, 1'b1, ROUTE_NONE, 8'h00, STATUS_NONE));
    for (int i = 0; i < 8; i++) dir_rows.push_back(row(KIND_DATA, MAGIC_RESET[8*i +: 8]));
    dir_rows.push_back(row(KIND_DATA, 8'h01));   // firmware size = 1
    dir_rows.push_back(row(KIND_DATA, 8'h00));
    dir_rows.push_back(row(KIND_DATA, 8'h00));
    dir_rows.push_back(row(KIND_DATA, 8'h00));
    dir_rows.push_back(row(KIND_DATA, 8'h01));   // filesystem size = 1
    dir_rows.push_back(row(KIND_DATA, 8'h00));
    dir_rows.push_back(row(KIND_DATA, 8'h00));
    dir_rows.push_back(row(KIND_DATA, 8'h00, 1'b1, ROUTE_NONE, 8'h00, STATUS_FW_BEGIN, 1, 0));
    dir_rows.push_back(row(KIND_DATA, 8'hFF, 1'b1, ROUTE_FW, 8'hFF, STATUS_FS_BEGIN, 1, 1));
    dir_rows.push_back(row(KIND_DATA, 8'h00, 1'b1, ROUTE_FS, 8'h00, STATUS_COMPLETE, 0, 2));
    // after completion bytes are dropped; end reports OK, twice over
    dir_rows.push_back(row(KIND_DATA, 8'h5A, 1'b1, ROUTE_NONE, 8'h00, STATUS_IGNORED, 0, 2));
    dir_rows.push_back(row(KIND_END, 8'h00, 1'b1, ROUTE_NONE, 8'h00, STATUS_END_OK, 0, 2));
    dir_rows.push_back(row(KIND_END, 8'h00, 1'b1, ROUTE_NONE, 8'h00, STATUS_END_OK, 0, 2));

    // magic settings: both extremes, a random one, then back to default
    magic_plan[0] = '0;
    magic_plan[1] = '1;
    magic_plan[2] = {$urandom, $urandom};
    magic_plan[3] = MAGIC_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      set_magic(magic_plan[ph]);
      phase_start = useful_words;
      while (useful_words - phase_start < WORDS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 65)      send_container(SHAPE_WELL_FORMED);
        else if (pick < 75) send_container(SHAPE_BAD_MAGIC);
        else if (pick < 83) send_container(SHAPE_ZERO_SIZE);
        else if (pick < 93) send_container(SHAPE_TRUNCATED);
        else                send_noise();
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
